// ----- rtl/tpe_pkg.sv -----
package tpe_pkg;

  localparam int unsigned TIME_BITS_DEF     = 32;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  // Log and exp resolution, Q1.30 working format
  localparam int unsigned LOG_BITS     = 24;
  localparam int unsigned FIX_BITS     = 30;

  // Power factor is unsigned Q8.8
  localparam int unsigned FACTOR_BITS  = 16;
  localparam int unsigned FACTOR_SHIFT = 8;
  localparam logic [FACTOR_BITS-1:0] FACTOR_ONE = 16'd256;

  // Register file
  localparam int unsigned ADDR_BITS = 4;
  localparam int unsigned DATA_BITS = 32;

  typedef enum logic [1:0] {
    REG_REPEAT = 2'd0,
    REG_CURVE  = 2'd1,
    REG_FACTOR = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    CURVE_LINEAR = 2'd0,
    CURVE_ACCEL  = 2'd1,
    CURVE_DECEL  = 2'd2
  } curve_e;

  typedef struct packed {
    logic                   repeat_mode;
    logic [1:0]             curve_kind;
    logic [FACTOR_BITS-1:0] power_factor;
  } cfg_t;

  // Integer square root, bit-pair method
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bit_q;
    rem   = v;
    root  = '0;
    bit_q = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (bit_q > rem) bit_q = bit_q >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bit_q != '0) begin
        if (rem >= root + bit_q) begin
          rem  = rem - (root + bit_q);
          root = (root >> 1) + bit_q;
        end else begin
          root = root >> 1;
        end
        bit_q = bit_q >> 2;
      end
    end
    return root;
  endfunction

  // 2^-(2^-idx) in Q1.30 by repeated square roots of one half
  function automatic logic [FIX_BITS:0] exp_coef(input int unsigned idx);
    logic [63:0] c;
    c = 64'd1 << (FIX_BITS - 1);
    for (int i = 0; i < LOG_BITS; i++) begin
      if (i < idx) c = isqrt64(c << FIX_BITS);
    end
    return c[FIX_BITS:0];
  endfunction

endpackage

// ----- rtl/tpe_in_if.sv -----
interface tpe_in_if #(
  parameter int unsigned TIME_BITS = tpe_pkg::TIME_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] start_tick;
  logic [TIME_BITS-1:0] goal_tick;
  logic [TIME_BITS-1:0] now_tick;

  modport source (output valid, start_tick, goal_tick, now_tick, input ready);
  modport sink   (input valid, start_tick, goal_tick, now_tick, output ready);
endinterface

// ----- rtl/tpe_out_if.sv -----
interface tpe_out_if #(
  parameter int unsigned FRACTION_BITS = tpe_pkg::FRACTION_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [FRACTION_BITS:0] progress;

  modport source (output valid, progress, input ready);
  modport sink   (input valid, progress, output ready);
endinterface

// ----- rtl/tpe_cfg.sv -----
module tpe_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel_i,
  input  logic                           penable_i,
  input  logic                           pwrite_i,
  input  logic [1:0]                     pindex_i,
  input  logic [tpe_pkg::DATA_BITS-1:0]  pwdata_i,
  output logic [tpe_pkg::DATA_BITS-1:0]  prdata_o,
  output tpe_pkg::cfg_t                  cfg_o
);

  tpe_pkg::cfg_t cfg_q;
  logic          wr;

  assign wr = psel_i & penable_i & pwrite_i;

  // Write on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.repeat_mode  <= 1'b0;
      cfg_q.curve_kind   <= tpe_pkg::CURVE_LINEAR;
      cfg_q.power_factor <= tpe_pkg::FACTOR_ONE;
    end else if (wr) begin
      case (pindex_i)
        tpe_pkg::REG_REPEAT: cfg_q.repeat_mode  <= pwdata_i[0];
        tpe_pkg::REG_CURVE:  cfg_q.curve_kind   <= pwdata_i[1:0];
        tpe_pkg::REG_FACTOR: cfg_q.power_factor <= pwdata_i[tpe_pkg::FACTOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (pindex_i)
      tpe_pkg::REG_REPEAT: prdata_o = tpe_pkg::DATA_BITS'(cfg_q.repeat_mode);
      tpe_pkg::REG_CURVE:  prdata_o = tpe_pkg::DATA_BITS'(cfg_q.curve_kind);
      tpe_pkg::REG_FACTOR: prdata_o = tpe_pkg::DATA_BITS'(cfg_q.power_factor);
      default:             prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/tpe_linear.sv -----
module tpe_linear #(
  parameter int unsigned TIME_BITS     = tpe_pkg::TIME_BITS_DEF,
  parameter int unsigned FRACTION_BITS = tpe_pkg::FRACTION_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [TIME_BITS-1:0]   start_i,
  input  logic [TIME_BITS-1:0]   goal_i,
  input  logic [TIME_BITS-1:0]   now_i,
  input  tpe_pkg::cfg_t          cfg_i,
  output logic                   valid_o,
  output logic [FRACTION_BITS:0] p_o
);

  localparam int unsigned W  = TIME_BITS;
  localparam int unsigned F  = FRACTION_BITS;
  localparam int unsigned NS = W + F;

  logic         v_q    [0:NS];
  logic         zero_q [0:NS];
  logic         one_q  [0:NS];
  logic [W-1:0] len_q  [0:NS];
  logic [W-1:0] rem_q  [0:NS];
  logic [F-1:0] q_q    [0:NS];
  logic [W-1:0] e_q    [0:W-1];

  logic zero_d, one_d;

  // Classify the query: before start, past goal (clamp mode only), or inside the interval
  always_comb begin
    if (cfg_i.repeat_mode) begin
      zero_d = (goal_i <= start_i) || (now_i < start_i);
      one_d  = 1'b0;
    end else begin
      zero_d = (now_i <= start_i);
      one_d  = !zero_d && (now_i >= goal_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q[0] <= 1'b0;
    else if (en_i) v_q[0] <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= zero_d;
      one_q[0]  <= one_d;
      len_q[0]  <= goal_i - start_i;
      e_q[0]    <= now_i - start_i;
      rem_q[0]  <= '0;
      q_q[0]    <= '0;
    end
  end

  // Carry valid, flags and length down the pipe
  for (genvar i = 1; i <= NS; i++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[i] <= 1'b0;
      else if (en_i) v_q[i] <= v_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i] <= zero_q[i-1];
        one_q[i]  <= one_q[i-1];
        len_q[i]  <= len_q[i-1];
      end
    end
  end

  // Elapsed modulo length, one dividend bit per stage
  for (genvar j = 0; j < W; j++) begin : g_mod
    logic [W:0] sh, df;
    assign sh = {rem_q[j], e_q[j][W-1-j]};
    assign df = sh - {1'b0, len_q[j]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1] <= df[W] ? sh[W-1:0] : df[W-1:0];
        q_q[j+1]   <= '0;
      end
    end
    if (j + 1 < W) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (en_i) e_q[j+1] <= e_q[j];
      end
    end
  end

  // Fraction of the length, one quotient bit per stage
  for (genvar k = 0; k < F; k++) begin : g_frac
    localparam int unsigned I = W + k;
    logic [W:0] sh, df;
    logic       qb;
    assign sh = {rem_q[I], 1'b0};
    assign df = sh - {1'b0, len_q[I]};
    assign qb = !df[W];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[I+1] <= qb ? df[W-1:0] : sh[W-1:0];
        q_q[I+1]   <= {q_q[I][F-2:0], qb};
      end
    end
  end

  assign valid_o = v_q[NS];
  assign p_o     = zero_q[NS] ? '0 :
                   one_q[NS]  ? {1'b1, {F{1'b0}}} : {1'b0, q_q[NS]};

endmodule

// ----- rtl/tpe_power.sv -----
module tpe_power #(
  parameter int unsigned FRACTION_BITS = tpe_pkg::FRACTION_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [FRACTION_BITS:0] p_i,
  input  tpe_pkg::cfg_t          cfg_i,
  output logic                   valid_o,
  output logic [FRACTION_BITS:0] progress_o
);

  localparam int unsigned F   = FRACTION_BITS;
  localparam int unsigned FB  = tpe_pkg::FIX_BITS;
  localparam int unsigned LB  = tpe_pkg::LOG_BITS;
  localparam int unsigned FCB = tpe_pkg::FACTOR_BITS;
  localparam int unsigned FS  = tpe_pkg::FACTOR_SHIFT;
  localparam int unsigned KB  = $clog2(F + 1);
  localparam int unsigned MB  = $clog2(F);
  localparam int unsigned NB  = LB + KB;
  localparam int unsigned YB  = NB + FS;
  localparam int unsigned S_N = LB + 1;
  localparam int unsigned S_Y = LB + 2;
  localparam int unsigned S_D = S_Y + YB;
  localparam int unsigned S_E = S_D + LB;
  localparam int unsigned S_O = S_E + 1;

  logic          v_q   [0:S_O];
  logic          byp_q [0:S_E];
  logic [F:0]    p_q   [0:S_E];
  logic [FB:0]   x_q   [0:LB];
  logic [LB-1:0] g_q   [0:LB];
  logic [MB-1:0] m_q   [0:LB];
  logic [NB-1:0] n_q;
  logic [YB-1:0] y_q   [S_Y:S_D];
  logic [YB-1:0] d_q   [S_Y:S_D];
  logic [FCB-1:0] dr_q [S_Y:S_D];
  logic [FB:0]   r_q   [S_D+1:S_E];
  logic [LB-1:0] f_q   [S_D+1:S_E];
  logic          kz_q  [S_D+1:S_E];
  logic [4:0]    sa_q  [S_D+1:S_E];
  logic [F:0]    out_q;

  logic [MB-1:0]  m_d;
  logic [4:0]     nsh;
  logic           byp_d;
  logic           accel;
  logic [FCB-1:0] fac;

  assign accel = (cfg_i.curve_kind == tpe_pkg::CURVE_ACCEL);
  assign fac   = (cfg_i.power_factor < tpe_pkg::FACTOR_ONE) ? tpe_pkg::FACTOR_ONE
                                                            : cfg_i.power_factor;

  // Leading one of the fraction
  always_comb begin
    m_d = '0;
    for (int i = 0; i < F; i++) begin
      if (p_i[i]) m_d = MB'(i);
    end
  end

  assign nsh   = 5'(FB) - 5'(m_d);
  assign byp_d = !(cfg_i.curve_kind == tpe_pkg::CURVE_ACCEL ||
                   cfg_i.curve_kind == tpe_pkg::CURVE_DECEL) ||
                 (p_i == '0) || p_i[F];

  // Normalize to [1,2)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q[0] <= 1'b0;
    else if (en_i) v_q[0] <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      byp_q[0] <= byp_d;
      p_q[0]   <= p_i;
      m_q[0]   <= m_d;
      x_q[0]   <= (FB+1)'(p_i[F-1:0]) << nsh;
      g_q[0]   <= '0;
    end
  end

  // Carry valid, bypass and linear value
  for (genvar i = 1; i <= S_O; i++) begin : g_valid
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[i] <= 1'b0;
      else if (en_i) v_q[i] <= v_q[i-1];
    end
  end

  for (genvar i = 1; i <= S_E; i++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        byp_q[i] <= byp_q[i-1];
        p_q[i]   <= p_q[i-1];
      end
    end
  end

  // Log fraction by repeated squaring, one bit per stage
  for (genvar i = 1; i <= LB; i++) begin : g_log
    logic [2*FB+1:0] sq;
    logic [FB+1:0]   t;
    assign sq = (2*FB+2)'(x_q[i-1]) * (2*FB+2)'(x_q[i-1]);
    assign t  = sq[2*FB+1:FB];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i] <= t[FB+1] ? t[FB+1:1] : t[FB:0];
        g_q[i] <= {g_q[i-1][LB-2:0], t[FB+1]};
        m_q[i] <= m_q[i-1];
      end
    end
  end

  // Negative log2 of the progress
  logic [KB-1:0] ip;
  assign ip = KB'(F) - KB'(m_q[LB]);

  always_ff @(posedge clk_i) begin
    if (en_i) n_q <= {ip, {LB{1'b0}}} - NB'(g_q[LB]);
  end

  // Scale by the factor, or load the divider for the inverse factor
  logic [NB+FCB-1:0] prod;
  assign prod = (NB+FCB)'(n_q) * (NB+FCB)'(fac);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q[S_Y]  <= accel ? prod[NB+FCB-1:FS] : '0;
      d_q[S_Y]  <= {n_q, {FS{1'b0}}};
      dr_q[S_Y] <= '0;
    end
  end

  // Restoring division by the factor, one quotient bit per stage
  for (genvar j = 0; j < YB; j++) begin : g_div
    localparam int unsigned I = S_Y + j;
    logic [FCB:0]   sh;
    logic [FCB+1:0] df;
    logic           qb;
    assign sh = {dr_q[I], d_q[I][YB-1-j]};
    assign df = {1'b0, sh} - {2'b00, fac};
    assign qb = !df[FCB+1];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dr_q[I+1] <= qb ? df[FCB-1:0] : sh[FCB-1:0];
        d_q[I+1]  <= d_q[I];
        y_q[I+1]  <= accel ? y_q[I] : {y_q[I][YB-2:0], qb};
      end
    end
  end

  // Exp2 of the fraction, one coefficient per stage
  for (genvar t = 1; t <= LB; t++) begin : g_exp
    localparam int unsigned I = S_D + t;
    localparam logic [FB:0] C = tpe_pkg::exp_coef(t);
    logic [FB:0]     r_src;
    logic [LB-1:0]   f_src;
    logic [2*FB+1:0] mp;
    if (t == 1) begin : g_first
      assign r_src = (FB+1)'(1) << FB;
      assign f_src = y_q[S_D][LB-1:0];
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          kz_q[I] <= (y_q[S_D][YB-1:LB] > (YB-LB)'(F));
          sa_q[I] <= 5'(FB - F) + 5'(y_q[S_D][YB-1:LB]);
        end
      end
    end else begin : g_next
      assign r_src = r_q[I-1];
      assign f_src = f_q[I-1];
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          kz_q[I] <= kz_q[I-1];
          sa_q[I] <= sa_q[I-1];
        end
      end
    end
    assign mp = (2*FB+2)'(r_src) * (2*FB+2)'(C);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[I] <= f_src[LB-t] ? mp[2*FB:FB] : r_src;
        f_q[I] <= f_src;
      end
    end
  end

  // Output word
  logic [FB:0] rs;
  assign rs = r_q[S_E] >> sa_q[S_E];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (byp_q[S_E])     out_q <= p_q[S_E];
      else if (kz_q[S_E]) out_q <= '0;
      else                out_q <= rs[F:0];
    end
  end

  assign valid_o    = v_q[S_O];
  assign progress_o = out_q;

endmodule

// ----- rtl/timed_progress_easing.sv -----
// Pipeline depth from input word to output word grows with TIME_BITS and
//   FRACTION_BITS through the bit-per-stage dividers.
// Throughput: one word per cycle; a stalled output freezes the whole pipeline.
// Reset: asynchronous, active low; clears all valid bits and sets the registers
//   to clamp mode, linear curve and a factor of 1.0.
module timed_progress_easing #(
  parameter int unsigned TIME_BITS     = tpe_pkg::TIME_BITS_DEF,
  parameter int unsigned FRACTION_BITS = tpe_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tpe_in_if.sink                         in_if,
  tpe_out_if.source                      out_if,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tpe_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [tpe_pkg::DATA_BITS-1:0]  pwdata,
  output logic [tpe_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready
);

  tpe_pkg::cfg_t          cfg;
  logic                   en;
  logic                   lin_valid;
  logic [FRACTION_BITS:0] lin_p;
  logic                   pw_valid;

  assign pready = 1'b1;

  tpe_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .pindex_i  (paddr[3:2]),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  // Advance unless the output word is held
  assign en          = !pw_valid || out_if.ready;
  assign in_if.ready = en;

  tpe_linear #(
    .TIME_BITS     (TIME_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_linear (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_if.valid),
    .start_i (in_if.start_tick),
    .goal_i  (in_if.goal_tick),
    .now_i   (in_if.now_tick),
    .cfg_i   (cfg),
    .valid_o (lin_valid),
    .p_o     (lin_p)
  );

  tpe_power #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_power (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (lin_valid),
    .p_i        (lin_p),
    .cfg_i      (cfg),
    .valid_o    (pw_valid),
    .progress_o (out_if.progress)
  );

  assign out_if.valid = pw_valid;

endmodule
